### design/absp_pkg.sv
// Package for the aligned byte pattern scanner: widths, register indexes,
// the window cell control struct and the pattern byte select function.
// Used by absp_cell and aligned_byte_pattern_scanner.
`default_nettype none

package absp_pkg;

  localparam int MaxPattern = 8;
  localparam int WinDepth   = MaxPattern - 1;
  localparam int PageBytes  = 4096;

  localparam int PosW   = $clog2(PageBytes);
  localparam int StartW = PosW + 1;
  localparam int LenW   = 4;
  localparam int StepW  = 7;
  localparam int IdxW   = $clog2(MaxPattern);
  localparam int PatW   = 8 * MaxPattern;
  localparam int CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_PATTERN_LENGTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_BYTES  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_MATCH_STEP     = CfgIdxW'(2);

  localparam logic [LenW-1:0]  LenReset  = LenW'(4);
  localparam logic [StepW-1:0] StepReset = StepW'(4);

  typedef struct packed {
    logic shift;
    logic clear;
  } absp_ctrl_t;

  function automatic logic [7:0] pattern_at(input logic [PatW-1:0] pat,
                                            input logic [IdxW-1:0] idx);
    pattern_at = pat[8*idx +: 8];
  endfunction

endpackage

`default_nettype wire

### design/absp_cell.sv
// One window cell: holds one past page byte, passes it to its neighbor on
// each accepted byte and compares it with its pattern byte. Uses absp_pkg.
`default_nettype none

module absp_cell
  import absp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire absp_ctrl_t ctrl_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] pat_i,
  input  wire logic       care_i,
  output logic [7:0]      byte_o,
  output logic            hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !care_i || (byte_q == pat_i);

endmodule

`default_nettype wire

### design/aligned_byte_pattern_scanner.sv
// Aligned byte pattern scanner top level: configuration registers, page
// offset tracking, the row of window cells and the result register.
// Uses absp_pkg and absp_cell.
//
// Usage: one page byte per input transaction (data_byte_i, page_last_i).
// A row of cells holds the previous seven bytes; with the current byte they
// are compared against the first pattern_length bytes of pattern_bytes.
// A match starting at or after the earliest permitted start gives a result
// with its start offset; page_last_i, or offset 4095, gives a result with
// page_end_o set and clears offset, window and permitted start.
// A result is registered and is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall_o is low.
// The result register holds a result while out_stall_i is high; a new byte
// is taken in that cycle only if out_valid_o is low.
// Configuration: cfg_ready_o is always high; writes to unknown indexes are
// dropped. Write only while the scanner is idle.
// Reset: pattern_length 4, pattern_bytes 0, match_step 4, window, offset
// and permitted start cleared, no result pending. No clearing pass.
`default_nettype none

module aligned_byte_pattern_scanner
  import absp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [PatW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               page_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    match_found_o,
  output logic [PosW-1:0]         match_offset_o,
  output logic                    page_end_o
);

  logic [LenW-1:0]   len_cfg_q;
  logic [PatW-1:0]   pat_q;
  logic [StepW-1:0]  step_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [StartW-1:0] early_q, early_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [PosW-1:0]   offset_q, offset_d;
  logic              end_q, end_d;

  logic              accept;
  logic [LenW-1:0]   len;
  logic [StartW-1:0] pos_p1;
  logic [StartW-1:0] start;
  logic              in_page;
  logic              cur_hit;
  logic              last;
  logic              found;
  logic [WinDepth-1:0] cell_hit;
  logic [7:0]        chain [WinDepth+1];
  absp_ctrl_t        ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LenReset;
      pat_q     <= '0;
      step_q    <= StepReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: len_cfg_q <= cfg_data_i[LenW-1:0];
        CFG_PATTERN_BYTES:  pat_q     <= cfg_data_i;
        CFG_MATCH_STEP:     step_q    <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len = len_cfg_q;
    if (len_cfg_q == '0) begin
      len = LenW'(1);
    end else if (len_cfg_q > LenW'(MaxPattern)) begin
      len = LenW'(MaxPattern);
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign last       = page_last_i || (pos_q == PosW'(PageBytes - 1));
  assign ctrl.shift = accept;
  assign ctrl.clear = accept && last;

  assign chain[0] = data_byte_i;

  for (genvar k = 0; k < WinDepth; k++) begin : g_cell
    logic            care;
    logic [LenW-1:0] idx_full;

    assign care     = LenW'(k + 1) < len;
    assign idx_full = len - LenW'(k + 2);

    absp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .byte_i (chain[k]),
      .pat_i  (pattern_at(pat_q, idx_full[IdxW-1:0])),
      .care_i (care),
      .byte_o (chain[k+1]),
      .hit_o  (cell_hit[k])
    );
  end

  always_comb begin
    logic [LenW-1:0] top_idx;
    top_idx = len - LenW'(1);
    cur_hit = data_byte_i == pattern_at(pat_q, top_idx[IdxW-1:0]);
    pos_p1  = StartW'(pos_q) + StartW'(1);
    in_page = pos_p1 >= StartW'(len);
    start   = pos_p1 - StartW'(len);
    found   = in_page && cur_hit && (&cell_hit) && (start >= early_q);
  end

  always_comb begin
    pos_d       = pos_q;
    early_d     = early_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    offset_d    = offset_q;
    end_d       = end_q;
    if (accept) begin
      if (last) begin
        pos_d   = '0;
        early_d = '0;
      end else begin
        pos_d = pos_p1[PosW-1:0];
        if (found) begin
          early_d = start + StartW'(step_q);
        end
      end
      if (found || last) begin
        out_valid_d = 1'b1;
        found_d     = found;
        offset_d    = found ? start[PosW-1:0] : '0;
        end_d       = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      early_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      early_q     <= early_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
    end_q    <= end_d;
  end

  assign out_valid_o    = out_valid_q;
  assign match_found_o  = found_q;
  assign match_offset_o = offset_q;
  assign page_end_o     = end_q;

endmodule

`default_nettype wire
